// ===== src/assert_macros.svh =====
// Assertion macros for the RTL files.
// Depends on nothing; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define BLPM_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// Implication checked at every clock edge outside reset.
`define BLPM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== src/blpm_pkg.sv =====
// Shared types and constants of the binary trie longest-prefix-match table.
// Depends on nothing.
`default_nettype none

package blpm_pkg;

   localparam int NODE_COUNT_DEF = 4096;
   localparam int ADDR_BITS_DEF  = 32;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic [2:0] STATUS_INSERTED  = 3'd0;
   localparam logic [2:0] STATUS_DUPLICATE = 3'd1;
   localparam logic [2:0] STATUS_FULL      = 3'd2;
   localparam logic [2:0] STATUS_HIT       = 3'd3;
   localparam logic [2:0] STATUS_MISS      = 3'd4;
   localparam logic [2:0] STATUS_CLEARED   = 3'd5;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] address;
      logic [31:0] route_mask;
      logic [31:0] next_hop;
      logic [7:0]  port_number;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] found_next_hop;
      logic [7:0]  found_port;
   } rsp_type;

   typedef struct packed {
      logic [31:0] hop;
      logic [7:0]  port;
   } route_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== src/binary_trie_longest_prefix_match.sv =====
// Top level: IPv4 longest-prefix-match table as a binary trie walker.
// Depends on blpm_pkg, blpm_store and assert_macros.svh.
//
//   channel | direction | ports                          | item
//   --------+-----------+--------------------------------+------------------------
//   req     | in        | req_valid, req_stall, req_item | command, prefix, route
//   rsp     | out       | rsp_valid, rsp_stall, rsp_item | status, next hop, port
//
// Insert and lookup: an accept step, one walk step per trie level visited
// (prefix length + 1, at most ADDR_BITS + 1) and a result step, the walk
// paced by the single node memory read per level. Clear and unused commands
// go from accept straight to the result step. Reset clears the root (root
// node kept in flops), no clearing pass. A stalled result holds in the
// output register; the next item walks meanwhile and waits only to deliver.
`default_nettype none

module binary_trie_longest_prefix_match #(
   parameter int NODE_COUNT = blpm_pkg::NODE_COUNT_DEF,
   parameter int ADDR_BITS  = blpm_pkg::ADDR_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire blpm_pkg::req_type req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output blpm_pkg::rsp_type      rsp_item
);
   import blpm_pkg::*;
   `include "assert_macros.svh"

   localparam int IDX_W   = $clog2(NODE_COUNT);
   localparam int CNT_W   = $clog2(NODE_COUNT + 1);
   localparam int LVL_W   = $clog2(ADDR_BITS + 1);
   localparam int ENTRY_W = 2 * IDX_W + 1;

   state_type            state_ff, state_in;
   logic [1:0]           cmd_ff, cmd_in;
   logic [ADDR_BITS-1:0] addr_sh_ff, addr_sh_in;
   logic [ADDR_BITS-1:0] mask_sh_ff, mask_sh_in;
   logic [31:0]          hop_ff, hop_in;
   logic [7:0]           port_ff, port_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;
   logic [LVL_W-1:0]     level_ff, level_in;
   logic                 fresh_ff, fresh_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   logic [IDX_W-1:0]     root_zero_ff, root_zero_in;
   logic [IDX_W-1:0]     root_one_ff, root_one_in;
   logic                 root_route_ff, root_route_in;
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [IDX_W-1:0]   rd_addr;
   logic               node_we;
   logic               route_we;
   logic [ENTRY_W-1:0] node_wdata;
   logic [ENTRY_W-1:0] node_q;
   route_type          route_q;

   logic [IDX_W-1:0] d_zero, d_one, slot;
   logic             d_route, at_end, addr_bit, mask_bit, pool_full;

   blpm_store #(
      .NODE_COUNT (NODE_COUNT),
      .ENTRY_W    (ENTRY_W)
   ) u_store (
      .clock       (clock),
      .rd_addr     (rd_addr),
      .node_we     (node_we),
      .route_we    (route_we),
      .wr_addr     (cur_ff),
      .node_wdata  (node_wdata),
      .route_wdata (route_type'{hop: hop_ff, port: port_ff}),
      .node_q      (node_q),
      .route_q     (route_q)
   );

   always_comb begin
      if (fresh_ff) begin
         d_zero  = '0;
         d_one   = '0;
         d_route = 1'b0;
      end else if (cur_ff == '0) begin
         d_zero  = root_zero_ff;
         d_one   = root_one_ff;
         d_route = root_route_ff;
      end else begin
         d_zero  = node_q[ENTRY_W-1 -: IDX_W];
         d_one   = node_q[IDX_W:1];
         d_route = node_q[0];
      end
   end

   assign addr_bit  = addr_sh_ff[ADDR_BITS-1];
   assign mask_bit  = mask_sh_ff[ADDR_BITS-1];
   assign at_end    = (level_ff == LVL_W'(ADDR_BITS));
   assign slot      = addr_bit ? d_one : d_zero;
   assign pool_full = (used_ff == CNT_W'(NODE_COUNT));

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      addr_sh_in    = addr_sh_ff;
      mask_sh_in    = mask_sh_ff;
      hop_in        = hop_ff;
      port_in       = port_ff;
      cur_in        = cur_ff;
      level_in      = level_ff;
      fresh_in      = fresh_ff;
      used_in       = used_ff;
      root_zero_in  = root_zero_ff;
      root_one_in   = root_one_ff;
      root_route_in = root_route_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      rd_addr       = '0;
      node_we       = 1'b0;
      route_we      = 1'b0;
      node_wdata    = {d_zero, d_one, d_route};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_item.cmd;
               addr_sh_in = req_item.address[ADDR_BITS-1:0];
               mask_sh_in = req_item.route_mask[ADDR_BITS-1:0];
               hop_in     = req_item.next_hop;
               port_in    = req_item.port_number;
               cur_in     = '0;
               level_in   = '0;
               fresh_in   = 1'b0;
               res_in     = '{status: STATUS_MISS, found_next_hop: '0, found_port: '0};
               case (req_item.cmd)
                  CMD_INSERT, CMD_LOOKUP: begin
                     state_in = ST_WALK;
                  end
                  CMD_CLEAR: begin
                     root_zero_in  = '0;
                     root_one_in   = '0;
                     root_route_in = 1'b0;
                     used_in       = CNT_W'(1);
                     res_in.status = STATUS_CLEARED;
                     state_in      = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_WALK: begin
            if (cmd_ff == CMD_LOOKUP) begin
               if (d_route) begin
                  res_in.status         = STATUS_HIT;
                  res_in.found_next_hop = route_q.hop;
                  res_in.found_port     = route_q.port;
               end
               if (at_end || slot == '0) begin
                  state_in = ST_DONE;
               end else begin
                  rd_addr    = slot;
                  cur_in     = slot;
                  level_in   = level_ff + LVL_W'(1);
                  addr_sh_in = {addr_sh_ff[ADDR_BITS-2:0], 1'b0};
               end
            end else if (at_end || !mask_bit) begin
               state_in = ST_DONE;
               if (d_route) begin
                  res_in.status = STATUS_DUPLICATE;
               end else begin
                  res_in.status = STATUS_INSERTED;
                  node_wdata    = {d_zero, d_one, 1'b1};
                  route_we      = 1'b1;
                  if (cur_ff == '0) begin
                     root_route_in = 1'b1;
                  end else begin
                     node_we = 1'b1;
                  end
               end
            end else if (slot != '0) begin
               rd_addr    = slot;
               cur_in     = slot;
               level_in   = level_ff + LVL_W'(1);
               addr_sh_in = {addr_sh_ff[ADDR_BITS-2:0], 1'b0};
               mask_sh_in = {mask_sh_ff[ADDR_BITS-2:0], 1'b0};
            end else if (pool_full) begin
               // a node allocated just before still has to land in memory
               res_in.status = STATUS_FULL;
               node_we       = fresh_ff;
               state_in      = ST_DONE;
            end else begin
               if (addr_bit) begin
                  node_wdata = {d_zero, used_ff[IDX_W-1:0], d_route};
               end else begin
                  node_wdata = {used_ff[IDX_W-1:0], d_one, d_route};
               end
               if (cur_ff == '0) begin
                  if (addr_bit) begin
                     root_one_in = used_ff[IDX_W-1:0];
                  end else begin
                     root_zero_in = used_ff[IDX_W-1:0];
                  end
               end else begin
                  node_we = 1'b1;
               end
               cur_in     = used_ff[IDX_W-1:0];
               used_in    = used_ff + CNT_W'(1);
               fresh_in   = 1'b1;
               level_in   = level_ff + LVL_W'(1);
               addr_sh_in = {addr_sh_ff[ADDR_BITS-2:0], 1'b0};
               mask_sh_in = {mask_sh_ff[ADDR_BITS-2:0], 1'b0};
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= CNT_W'(1);
         root_zero_ff  <= '0;
         root_one_ff   <= '0;
         root_route_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fresh_ff      <= 1'b0;
         cur_ff        <= '0;
         level_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         root_zero_ff  <= root_zero_in;
         root_one_ff   <= root_one_in;
         root_route_ff <= root_route_in;
         rsp_valid_ff  <= rsp_valid_in;
         fresh_ff      <= fresh_in;
         cur_ff        <= cur_in;
         level_ff      <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      addr_sh_ff <= addr_sh_in;
      mask_sh_ff <= mask_sh_in;
      hop_ff     <= hop_in;
      port_ff    <= port_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `BLPM_ASSERT_ALWAYS(a_used_range, clock, reset,
      used_ff != '0 && used_ff <= CNT_W'(NODE_COUNT), "node count out of range")
   `BLPM_ASSERT_IMPLY(a_fresh_not_root, clock, reset,
      fresh_ff, cur_ff != '0, "fresh node flag on root")
   `BLPM_ASSERT_IMPLY(a_no_root_mem_write, clock, reset,
      node_we, cur_ff != '0, "root node written to memory")
   `BLPM_ASSERT_ALWAYS(a_level_bound, clock, reset,
      level_ff <= LVL_W'(ADDR_BITS), "walk deeper than address width")

endmodule

`default_nettype wire

// ===== src/blpm_store.sv =====
// Node and route memories of the trie, one write and one registered read each.
// Depends on blpm_pkg.
`default_nettype none

module blpm_store #(
   parameter int NODE_COUNT = blpm_pkg::NODE_COUNT_DEF,
   parameter int ENTRY_W    = 2 * $clog2(blpm_pkg::NODE_COUNT_DEF) + 1
) (
   input  wire logic                          clock,
   input  wire logic [$clog2(NODE_COUNT)-1:0] rd_addr,
   input  wire logic                          node_we,
   input  wire logic                          route_we,
   input  wire logic [$clog2(NODE_COUNT)-1:0] wr_addr,
   input  wire logic [ENTRY_W-1:0]            node_wdata,
   input  wire blpm_pkg::route_type           route_wdata,
   output logic      [ENTRY_W-1:0]            node_q,
   output blpm_pkg::route_type                route_q
);
   import blpm_pkg::*;

   logic [ENTRY_W-1:0] node_mem [NODE_COUNT];
   route_type          route_mem [NODE_COUNT];

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[wr_addr] <= node_wdata;
      end
      node_q <= node_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (route_we) begin
         route_mem[wr_addr] <= route_wdata;
      end
      route_q <= route_mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== tb/binary_trie_longest_prefix_match_test.sv =====
// Testbench for binary_trie_longest_prefix_match: trie route insert, lookup, clear and
// pool exhaustion, checked item by item against a predictor of the routing table.
// Depends on blpm_pkg and the binary_trie_longest_prefix_match RTL.
module binary_trie_longest_prefix_match_test;
   timeunit 1ns;
   timeprecision 1ps;
   import blpm_pkg::*;

   localparam int TRIE_NODES = NODE_COUNT_DEF;
   localparam int ADDR_W = ADDR_BITS_DEF;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = ADDR_W + 8;
   localparam int RUN_LIMIT_NS = 10_000_000;

   typedef struct packed {
      logic [31:0] prefix;
      logic [31:0] mask;
   } prefix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_item;

   // routing table predictor
   int unsigned zero_link [TRIE_NODES];
   int unsigned one_link [TRIE_NODES];
   bit route_valid [TRIE_NODES];
   route_type route_data [TRIE_NODES];
   int unsigned pool_used;

   rsp_type expected_responses [$];
   prefix_type known_prefixes [$];
   logic [31:0] region_base [8];
   logic [2:0] last_status;
   int error_count = 0;

   bit sender_idles = 1'b1;
   bit receiver_stalls = 1'b1;
   int hold_requests = 0;
   int hold_length = 0;
   int holds_served = 0;
   int hold_left = 0;
   int stall_left = 0;

   binary_trie_longest_prefix_match dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("TEST FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] prefix_mask(input int len);
      return 32'hFFFF_FFFF << (32 - len);
   endfunction

   function automatic req_type make_item(input logic [1:0] cmd, input logic [31:0] address,
                                         input logic [31:0] mask, input logic [31:0] hop,
                                         input logic [7:0] port);
      req_type item;
      item.cmd = cmd;
      item.address = address;
      item.route_mask = mask;
      item.next_hop = hop;
      item.port_number = port;
      return item;
   endfunction

   function automatic void clear_trie();
      pool_used = 1;
      zero_link[0] = 0;
      one_link[0] = 0;
      route_valid[0] = 1'b0;
   endfunction

   function automatic logic [2:0] trie_insert(input req_type item);
      int unsigned node;
      int unsigned child;
      bit dir;
      node = 0;
      for (int level = 0; level < ADDR_W; level++) begin
         if (!item.route_mask[ADDR_W - 1 - level]) break;
         dir = item.address[ADDR_W - 1 - level];
         child = dir ? one_link[node] : zero_link[node];
         if (child == 0) begin
            if (pool_used >= TRIE_NODES) return STATUS_FULL;
            child = pool_used;
            pool_used++;
            zero_link[child] = 0;
            one_link[child] = 0;
            route_valid[child] = 1'b0;
            if (dir) one_link[node] = child;
            else zero_link[node] = child;
         end
         node = child;
      end
      if (route_valid[node]) return STATUS_DUPLICATE;
      route_valid[node] = 1'b1;
      route_data[node].hop = item.next_hop;
      route_data[node].port = item.port_number;
      return STATUS_INSERTED;
   endfunction

   function automatic rsp_type trie_lookup(input logic [31:0] address);
      rsp_type r;
      int unsigned node;
      int unsigned child;
      r = '0;
      r.status = STATUS_MISS;
      node = 0;
      for (int level = 0; level <= ADDR_W; level++) begin
         if (route_valid[node]) begin
            r.status = STATUS_HIT;
            r.found_next_hop = route_data[node].hop;
            r.found_port = route_data[node].port;
         end
         if (level == ADDR_W) break;
         child = address[ADDR_W - 1 - level] ? one_link[node] : zero_link[node];
         if (child == 0) break;
         node = child;
      end
      return r;
   endfunction

   function automatic rsp_type predict_response(input req_type item);
      rsp_type r;
      r = '0;
      case (item.cmd)
         CMD_INSERT: r.status = trie_insert(item);
         CMD_LOOKUP: r = trie_lookup(item.address);
         CMD_CLEAR: begin
            clear_trie();
            r.status = STATUS_CLEARED;
         end
         default: r.status = STATUS_MISS;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   // sender: called on a rising edge, returns on the edge that accepts the item
   task automatic send_item(input req_type item);
      rsp_type r;
      int gap;
      gap = sender_idles ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = predict_response(item);
      last_status = r.status;
      expected_responses.push_back(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_responses.size() != 0) @(posedge clock);
   endtask

   // receiver: random stall runs plus requested long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
         holds_served <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left <= hold_length;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (!receiver_stalls) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_responses.size() == 0) begin
            report_mismatch($sformatf("item with nothing pending, status %0d", rsp_item.status));
         end else begin
            want = expected_responses.pop_front();
            if (rsp_item.status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d",
                                         rsp_item.status, want.status));
            if (rsp_item.found_next_hop !== want.found_next_hop)
               report_mismatch($sformatf("next hop got %h want %h",
                                         rsp_item.found_next_hop, want.found_next_hop));
            if (rsp_item.found_port !== want.found_port)
               report_mismatch($sformatf("port got %h want %h",
                                         rsp_item.found_port, want.found_port));
         end
      end
   end

   task automatic test_empty_and_default();
      send_item(make_item(CMD_LOOKUP, 32'h0, 32'h0, 32'h0, 8'h00));
      send_item(make_item(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
      send_item(make_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
      send_item(make_item(CMD_INSERT, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF, 8'hFF));
      send_item(make_item(CMD_LOOKUP, 32'h0, 32'h0, 32'h0, 8'h00));
      send_item(make_item(CMD_INSERT, 32'hFFFF_FFFF, 32'h0, 32'h1, 8'h01));
      send_item(make_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
   endtask

   task automatic test_prefix_walks();
      send_item(make_item(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 8'h00));
      send_item(make_item(CMD_INSERT, 32'h0, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 8'h5A));
      send_item(make_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'h00));
      send_item(make_item(CMD_LOOKUP, 32'h0, 32'h0, 32'h0, 8'h00));
      send_item(make_item(CMD_LOOKUP, 32'hFFFF_FFFE, 32'h0, 32'h0, 8'h00));
      send_item(make_item(CMD_INSERT, 32'h0A00_0000, prefix_mask(8), 32'h0A00_0001, 8'h01));
      send_item(make_item(CMD_INSERT, 32'h0A01_0200, prefix_mask(24), 32'h0A01_0201, 8'h02));
      send_item(make_item(CMD_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 8'h00));
      send_item(make_item(CMD_LOOKUP, 32'h0A01_0303, 32'h0, 32'h0, 8'h00));
      // holes in the mask: only the leading run of ones counts
      send_item(make_item(CMD_INSERT, 32'hC0A8_0000, 32'hFF00_FF00, 32'hC000_0001, 8'h03));
      send_item(make_item(CMD_LOOKUP, 32'hC0FF_FFFF, 32'h0, 32'h0, 8'h00));
      send_item(make_item(CMD_INSERT, 32'hC012_3456, prefix_mask(8), 32'h7, 8'h07));
      send_item(make_item(CMD_INSERT, 32'h0A01_0200, prefix_mask(24), 32'h8, 8'h08));
      send_item(make_item(CMD_INSERT, 32'h8000_0000, prefix_mask(1), 32'h3, 8'h04));
      send_item(make_item(CMD_LOOKUP, 32'h8000_0001, 32'h0, 32'h0, 8'h00));
      send_item(make_item(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 8'h00));
      send_item(make_item(CMD_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 8'h00));
   endtask

   task automatic test_pool_exhaustion();
      logic [31:0] address;
      prefix_type kp;
      send_item(make_item(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 8'h00));
      for (int n = 0; n < 300 && last_status != STATUS_FULL; n++) begin
         address = $urandom();
         send_item(make_item(CMD_INSERT, address, 32'hFFFF_FFFF, $urandom(), 8'($urandom())));
         kp.prefix = address;
         kp.mask = 32'hFFFF_FFFF;
         if (last_status == STATUS_INSERTED) known_prefixes.push_back(kp);
      end
      for (int n = 0; n < 4 && known_prefixes.size() != 0; n++) begin
         kp = known_prefixes[$urandom_range(0, known_prefixes.size() - 1)];
         send_item(make_item(CMD_LOOKUP, kp.prefix, 32'h0, 32'h0, 8'h00));
      end
      // root route needs no new node even with the pool used up
      send_item(make_item(CMD_INSERT, $urandom(), 32'h0, $urandom(), 8'($urandom())));
      send_item(make_item(CMD_INSERT, $urandom(), 32'hFFFF_FFFF, $urandom(), 8'($urandom())));
      send_item(make_item(CMD_LOOKUP, $urandom(), 32'h0, 32'h0, 8'h00));
      send_item(make_item(CMD_CLEAR, 32'h0, 32'h0, 32'h0, 8'h00));
      send_item(make_item(CMD_LOOKUP, $urandom(), 32'h0, 32'h0, 8'h00));
      known_prefixes.delete();
   endtask

   task automatic send_random_item();
      req_type item;
      prefix_type kp;
      int pick;
      int len;
      item.cmd = CMD_LOOKUP;
      item.address = $urandom();
      item.route_mask = $urandom();
      item.next_hop = $urandom();
      item.port_number = 8'($urandom());
      pick = $urandom_range(0, 999);
      if (pick < 420) begin
         item.cmd = CMD_INSERT;
         if ($urandom_range(0, 4) != 0)
            item.address = region_base[$urandom_range(0, 7)] ^
                           ($urandom() & (32'hFFFF_FFFF >> $urandom_range(6, 32)));
         case ($urandom_range(0, 9))
            0: len = $urandom_range(0, 4);
            1, 2, 3: len = $urandom_range(5, 24);
            default: len = $urandom_range(20, 32);
         endcase
         if ($urandom_range(0, 19) != 0) begin
            item.route_mask = prefix_mask(len);
            kp.prefix = item.address;
            kp.mask = item.route_mask;
            known_prefixes.push_back(kp);
            if (known_prefixes.size() > 200) void'(known_prefixes.pop_front());
         end
      end else if (pick < 950) begin
         if (known_prefixes.size() != 0 && $urandom_range(0, 4) != 0) begin
            kp = known_prefixes[$urandom_range(0, known_prefixes.size() - 1)];
            item.address = (kp.prefix & kp.mask) | ($urandom() & ~kp.mask);
         end
      end else if (pick < 996) begin
         item.cmd = CMD_UNUSED;
      end else begin
         item.cmd = CMD_CLEAR;
         known_prefixes.delete();
      end
      send_item(item);
   endtask

   task automatic test_backpressure();
      sender_idles = 1'b0;
      hold_length <= 400;
      hold_requests <= hold_requests + 1;
      for (int n = 0; n < 30; n++) send_random_item();
      wait_drained();
      sender_idles = 1'b1;
   endtask

   task automatic test_random_traffic(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 150 == 0) begin
            sender_idles = ($urandom_range(0, 3) != 0);
            receiver_stalls <= ($urandom_range(0, 3) != 0);
         end
         send_random_item();
      end
   endtask

   initial begin
      clear_trie();
      foreach (region_base[k]) region_base[k] = $urandom();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_default();
      test_prefix_walks();
      test_pool_exhaustion();
      test_backpressure();
      test_random_traffic(1300);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_responses.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/blpm_pkg.sv
src/blpm_store.sv
src/binary_trie_longest_prefix_match.sv
tb/binary_trie_longest_prefix_match_test.sv
